// ===== rtl/srfp_pkg.sv =====
// Package with the shared types, widths and constants of the servo ramp and fire pattern block.
package srfp_pkg;

    localparam int CMD_W      = 2;
    localparam int ELAPSED_W  = 16;
    localparam int RATE_W     = 21;
    localparam int SHOT_W     = 24;
    localparam int DUTY_W     = 10;
    localparam int PAT_W      = 8;
    localparam int PWM_W      = 16;
    localparam int ANGLE_W    = 38;
    localparam int ACC_W      = 39;
    localparam int NUM_W      = 48;
    localparam int QUOT_W     = 7;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam longint NDEG_PER_DEG = 64'sd1_000_000_000;
    localparam longint CENTER_NDEG  = 64'sd90 * NDEG_PER_DEG;
    localparam longint DUTY_OFS     = 64'sd45 * NDEG_PER_DEG;
    localparam longint DUTY_DIV     = 64'sd1800 * NDEG_PER_DEG;

    localparam logic [ANGLE_W-1:0] ANGLE_CENTER = ANGLE_W'(CENTER_NDEG);
    localparam logic [DUTY_W-1:0]  DUTY_CENTER  =
        DUTY_W'((64'sd1023 * (DUTY_OFS + CENTER_NDEG)) / DUTY_DIV);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 2'd0,
        CMD_ARM     = 2'd1,
        CMD_ENABLE  = 2'd2,
        CMD_DISABLE = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INJECT_ON     = 2'd0,
        REG_INJECT_PERIOD = 2'd1,
        REG_INJECT_HIGH   = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DUTY,
        ST_FIRE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             inject_on;
        logic [PWM_W-1:0] period;
        logic [PWM_W-1:0] high;
        logic             fire_all;
    } fire_ctl_t;

endpackage

// ===== rtl/srfp_mul.sv =====
// Bit-serial rate times elapsed time accumulator with pitch clamp.
module srfp_mul #(
    parameter int PITCH_LIMIT_DEG = 30
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [srfp_pkg::ANGLE_W-1:0]        angle_in,
    input  logic signed [srfp_pkg::RATE_W-1:0]  rate,
    input  logic [srfp_pkg::ELAPSED_W-1:0]      elapsed,
    output logic                                done,
    output logic [srfp_pkg::ANGLE_W-1:0]        angle_out
);
    import srfp_pkg::*;

    localparam int CNT_W = $clog2(ELAPSED_W);
    localparam logic signed [ACC_W-1:0] ANG_LO =
        ACC_W'((64'sd90 - PITCH_LIMIT_DEG) * NDEG_PER_DEG);
    localparam logic signed [ACC_W-1:0] ANG_HI =
        ACC_W'((64'sd90 + PITCH_LIMIT_DEG) * NDEG_PER_DEG);

    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   mcand_reg;
    logic [ELAPSED_W-1:0]      mplier_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      fin_reg;
    logic                      done_reg;
    logic [ANGLE_W-1:0]        angle_reg;
    logic signed [ACC_W-1:0]   clamp_val;

    always_comb begin
        clamp_val = acc_reg;
        if (acc_reg < ANG_LO) begin
            clamp_val = ANG_LO;
        end else if (acc_reg > ANG_HI) begin
            clamp_val = ANG_HI;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(ELAPSED_W - 1)) begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end else if (fin_reg) begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg    <= signed'({1'b0, angle_in});
            mcand_reg  <= {{(ACC_W - RATE_W){rate[RATE_W-1]}}, rate};
            mplier_reg <= elapsed;
            cnt_reg    <= '0;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
            cnt_reg    <= cnt_reg + 1'b1;
        end
        if (fin_reg) begin
            angle_reg <= clamp_val[ANGLE_W-1:0];
        end
    end

    assign done      = done_reg;
    assign angle_out = angle_reg;

endmodule

// ===== rtl/srfp_duty.sv =====
// Restoring divider that maps the clamped angle onto the servo duty, one quotient bit per cycle.
module srfp_duty (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [srfp_pkg::ANGLE_W-1:0]   angle,
    output logic                           done,
    output logic [srfp_pkg::QUOT_W-1:0]    quot
);
    import srfp_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W);
    localparam logic [NUM_W-1:0] DVS_TOP = NUM_W'(DUTY_DIV << (QUOT_W - 1));

    logic [ANGLE_W-1:0] x_reg;
    logic [NUM_W-1:0]   rem_reg;
    logic [NUM_W-1:0]   dvs_reg;
    logic [QUOT_W-1:0]  q_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               load_reg;
    logic               busy_reg;
    logic               done_reg;
    logic               fits;

    assign fits = (rem_reg >= dvs_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            load_reg <= start;
            if (load_reg) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(QUOT_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= ANGLE_W'(DUTY_OFS) + angle;
        end
        if (load_reg) begin
            rem_reg <= {x_reg, 10'b0} - {10'b0, x_reg};
            dvs_reg <= DVS_TOP;
            q_reg   <= '0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= rem_reg - dvs_reg;
            end
            q_reg   <= {q_reg[QUOT_W-2:0], fits};
            dvs_reg <= dvs_reg >> 1;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== rtl/srfp_fire.sv =====
// Slot-serial fire pattern generator with the injection PWM counter.
module srfp_fire #(
    parameter int SLOTS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  srfp_pkg::fire_ctl_t   ctl,
    output logic                  done,
    output logic [SLOTS-1:0]      pattern
);
    import srfp_pkg::*;

    localparam int CNT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    fire_ctl_t          ctl_reg;
    logic [PWM_W-1:0]   pwm_reg;
    logic [PWM_W-1:0]   pwm_inc;
    logic [PWM_W-1:0]   pwm_next;
    logic [SLOTS-1:0]   pat_reg;
    logic [SLOTS:0]     pat_shift;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic               slot_bit;

    always_comb begin
        pwm_inc   = pwm_reg + 1'b1;
        pwm_next  = (pwm_inc >= ctl_reg.period) ? '0 : pwm_inc;
        slot_bit  = ctl_reg.inject_on ? (pwm_next < ctl_reg.high) : ctl_reg.fire_all;
        pat_shift = {slot_bit, pat_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            pwm_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (ctl_reg.inject_on) begin
                    pwm_reg <= pwm_next;
                end
                if (cnt_reg == CNT_W'(SLOTS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            ctl_reg <= ctl;
            pat_reg <= '0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            pat_reg <= pat_shift[SLOTS:1];
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign done    = done_reg;
    assign pattern = pat_reg;

endmodule

// ===== rtl/servo_ramp_and_fire_pattern.sv =====
// Top level of the servo ramp and fire pattern block: control sequencer, state and ports.
//
//   Channel   Ports                    Word
//   input     s_tvalid/s_tready        s_tuser command, s_tdata tick and arm fields
//   result    m_tvalid/m_tready        m_tdata duty, fire pattern, servo on
//   config    cfg_valid/cfg_ready      cfg_index register, cfg_data value
//
// A tick runs the bit-serial multiply and clamp, then the restoring duty divider only
// with the servo enabled, then the pattern, and then loads the output register and
// returns to idle. A command goes straight to loading the output register.
// Reset is synchronous and clears the control state; there is no clearing pass.
// A stalled result waits in the output register while the next word is accepted.
module servo_ramp_and_fire_pattern #(
    parameter int SLOTS           = 8,
    parameter int PITCH_LIMIT_DEG = 30
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // elapsed_us, rate_mdeg_per_s, continuous_fire, shot_time_us, zero pad
    input  logic [srfp_pkg::IN_DATA_W-1:0]       s_tdata,
    // command
    input  logic [srfp_pkg::CMD_W-1:0]           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // servo_duty, fire_pattern, servo_on, zero pad
    output logic [srfp_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [srfp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [srfp_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import srfp_pkg::*;

    state_t                     state_reg;
    state_t                     state_next;
    logic                       mul_start;
    logic                       duty_start;
    logic                       fire_start;
    logic                       mul_done;
    logic                       duty_done;
    logic                       fire_done;
    logic [ANGLE_W-1:0]         mul_angle;
    logic [QUOT_W-1:0]          duty_quot;
    logic [SLOTS-1:0]           fire_pat;
    logic [SLOTS+PAT_W-1:0]     pat_ext;
    fire_ctl_t                  fire_ctl;

    logic                       inject_on_reg;
    logic [PWM_W-1:0]           inject_period_reg;
    logic [PWM_W-1:0]           inject_high_reg;
    logic [ANGLE_W-1:0]         angle_reg;
    logic                       servo_en_reg;
    logic [DUTY_W-1:0]          duty_reg;
    logic [SHOT_W-1:0]          shot_reg;
    logic [PAT_W-1:0]           pattern_reg;
    logic                       cont_reg;
    logic                       out_vld_reg;
    logic [OUT_DATA_W-1:0]      out_data_reg;

    cmd_t                       s_cmd;
    logic [ELAPSED_W-1:0]       s_elapsed;
    logic signed [RATE_W-1:0]   s_rate;
    logic                       s_cont;
    logic [SHOT_W-1:0]          s_shot;
    logic                       accept;
    logic                       out_free;

    assign s_cmd     = cmd_t'(s_tuser);
    assign s_elapsed = s_tdata[15:0];
    assign s_rate    = signed'(s_tdata[36:16]);
    assign s_cont    = s_tdata[37];
    assign s_shot    = s_tdata[61:38];
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_vld_reg || m_tready;
    assign cfg_ready = 1'b1;

    assign fire_ctl.inject_on = inject_on_reg;
    assign fire_ctl.period    = inject_period_reg;
    assign fire_ctl.high      = inject_high_reg;
    assign fire_ctl.fire_all  = cont_reg || (shot_reg != '0);
    assign pat_ext            = {{PAT_W{1'b0}}, fire_pat};

    srfp_mul #(
        .PITCH_LIMIT_DEG(PITCH_LIMIT_DEG)
    ) u_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mul_start),
        .angle_in (angle_reg),
        .rate     (s_rate),
        .elapsed  (s_elapsed),
        .done     (mul_done),
        .angle_out(mul_angle)
    );

    srfp_duty u_duty (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (duty_start),
        .angle  (mul_angle),
        .done   (duty_done),
        .quot   (duty_quot)
    );

    srfp_fire #(
        .SLOTS(SLOTS)
    ) u_fire (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (fire_start),
        .ctl    (fire_ctl),
        .done   (fire_done),
        .pattern(fire_pat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        mul_start  = 1'b0;
        duty_start = 1'b0;
        fire_start = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_cmd == CMD_TICK) begin
                        mul_start  = 1'b1;
                        state_next = ST_MUL;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    if (servo_en_reg) begin
                        duty_start = 1'b1;
                        state_next = ST_DUTY;
                    end else begin
                        fire_start = 1'b1;
                        state_next = ST_FIRE;
                    end
                end
            end
            ST_DUTY: begin
                if (duty_done) begin
                    fire_start = 1'b1;
                    state_next = ST_FIRE;
                end
            end
            ST_FIRE: begin
                if (fire_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inject_on_reg     <= 1'b0;
            inject_period_reg <= '0;
            inject_high_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_INJECT_ON:     inject_on_reg     <= cfg_data[0];
                REG_INJECT_PERIOD: inject_period_reg <= cfg_data;
                REG_INJECT_HIGH:   inject_high_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg    <= ANGLE_CENTER;
            servo_en_reg <= 1'b0;
            duty_reg     <= '0;
            shot_reg     <= '0;
            pattern_reg  <= '0;
            cont_reg     <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (accept) begin
                unique case (s_cmd)
                    CMD_TICK: begin
                        cont_reg <= s_cont;
                        shot_reg <= (shot_reg > SHOT_W'(s_elapsed)) ?
                                    shot_reg - SHOT_W'(s_elapsed) : '0;
                    end
                    CMD_ARM: begin
                        shot_reg <= s_shot;
                    end
                    CMD_ENABLE: begin
                        if (!servo_en_reg) begin
                            servo_en_reg <= 1'b1;
                            duty_reg     <= DUTY_CENTER;
                        end
                    end
                    CMD_DISABLE: begin
                        if (servo_en_reg) begin
                            servo_en_reg <= 1'b0;
                            duty_reg     <= '0;
                            shot_reg     <= '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (state_reg == ST_MUL && mul_done) begin
                angle_reg <= mul_angle;
            end
            if (duty_done) begin
                duty_reg <= DUTY_W'(duty_quot);
            end
            if (fire_done) begin
                pattern_reg <= pat_ext[PAT_W-1:0];
            end
            if (state_reg == ST_OUT && out_free) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            out_data_reg <= {{(OUT_DATA_W - DUTY_W - PAT_W - 1){1'b0}},
                             servo_en_reg, pattern_reg, duty_reg};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    a_duty_zero_off: assert property (@(posedge aclk) disable iff (!aresetn)
        !servo_en_reg |-> duty_reg == '0)
        else $error("Duty is nonzero while the servo is disabled.");

    a_word_duty_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !out_data_reg[DUTY_W+PAT_W]) |-> out_data_reg[DUTY_W-1:0] == '0)
        else $error("Result word carries a duty with the servo off.");

    a_mul_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> state_reg == ST_MUL)
        else $error("Multiplier finished outside its wait state.");

    a_fire_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        fire_done |-> state_reg == ST_FIRE)
        else $error("Pattern generator finished outside its wait state.");

endmodule
